@@ src/brlr_pkg.sv @@
package brlr_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_FILL  = 2'd1,
        ACT_LINE  = 2'd2,
        ACT_READ  = 2'd3
    } brlr_action_t;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_SAMPLE,
        S_BOX,
        S_SQ,
        S_TEST,
        S_BLEND,
        S_RDREQ,
        S_RDWAIT,
        S_DONE
    } brlr_state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [11:0]        line_width;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } brlr_cmd_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
        logic       read_valid;
    } brlr_pix_t;

endpackage

@@ src/brlr_ram.sv @@
module brlr_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ src/blended_rect_line_rasterizer_top.sv @@
// channel | valid / ready      | payload
// s_      | s_valid / s_ready  | s_data   (brlr_cmd_t, one command)
// m_      | m_valid / m_ready  | m_data   (brlr_pix_t, one result per command)
// cfg_    | cfg_valid / cfg_ready | cfg_index, cfg_data (frame width, height)
//
// one command at a time; every blended pixel is a read then a write on the single store port
// clear: writes every store word in turn; fill: reads, tests and blends each covered pixel
// line: a serial divide per axis, then per sample a box walk that reads, tests and stamps disc pixels
// read: a store read, then the result; the next command is taken while a result waits for m_ready
// reset clears control only; the store holds nothing valid until the first clear
module blended_rect_line_rasterizer_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  brlr_pkg::brlr_cmd_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output brlr_pkg::brlr_pix_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data
);
    import brlr_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int CH    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [12:0] clamp13(logic signed [23:0] v, logic [12:0] lim);
        logic [12:0] r;
        if (v < 0) begin
            r = 13'd0;
        end else if (v > $signed({11'd0, lim})) begin
            r = lim;
        end else begin
            r = v[12:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] mix(logic [7:0] c, logic [7:0] d, logic [7:0] a);
        logic [16:0] t;
        logic [16:0] q;
        t = 17'(c) * 17'(a) + 17'(d) * 17'(8'd255 - a) + 17'd127;
        q = (t + (t >> 8) + 17'd1) >> 8;
        return q[7:0];
    endfunction

    brlr_state_t state_reg, state_next;
    logic [8:0]  fw_reg, fw_next, fh_reg, fh_next;
    logic        m_valid_reg, m_valid_next;

    logic [CW-1:0] px_reg, px_next, x0_reg, x0_next, x1_reg, x1_next;
    logic [CH-1:0] py_reg, py_next, y0_reg, y0_next, y1_reg, y1_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [31:0]   color_reg, color_next;
    logic signed [15:0] sx_reg, sx_next, sy_reg, sy_next;
    logic          negx_reg, negx_next, negy_reg, negy_next, line_reg, line_next;
    logic [12:0]   steps_reg, steps_next, s_reg, s_next;
    logic [19:0]   numx_reg, numx_next, numy_reg, numy_next;
    logic [13:0]   remx_reg, remx_next, remy_reg, remy_next;
    logic [4:0]    div_reg, div_next;
    logic signed [20:0] qfx_reg, qfx_next, qfy_reg, qfy_next;
    logic [12:0]   rfx_reg, rfx_next, rfy_reg, rfy_next;
    logic signed [23:0] accx_reg, accx_next, accy_reg, accy_next;
    logic [12:0]   racx_reg, racx_next, racy_reg, racy_next;
    logic [14:0]   r8_reg, r8_next;
    logic [29:0]   r2_reg, r2_next;
    logic signed [23:0] xs_reg, xs_next, ys_reg, ys_next;
    logic [31:0]   sqx_reg, sqx_next, sqy_reg, sqy_next;
    brlr_pix_t     res_reg, res_next, out_reg, out_next;

    logic [12:0]   fw13, fh13;
    logic [AW-1:0] pix_addr, ram_addr;
    logic          ram_we;
    logic [31:0]   ram_wdata, ram_rdata, blend_word;

    logic signed [16:0] dx_c, dy_c;
    logic [16:0]   adx_c, ady_c, m_c, st17_c;
    logic [11:0]   lwm_c;
    logic [14:0]   r8_c;
    logic [12:0]   rdx_c, rdy_c;
    logic signed [23:0] t24a, t24b;
    logic [13:0]   remx_sh, remy_sh, racx_sum, racy_sum;
    logic signed [23:0] xs_c, ys_c, r8s, ox_c, oy_c;
    logic signed [16:0] ox17, oy17;
    logic signed [33:0] sqx_full, sqy_full;
    logic [32:0]   sq_sum;
    logic          hit_c, box_empty, adv_px, adv_py, more_samples;

    assign fw13 = ({4'd0, fw_reg} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, fw_reg};
    assign fh13 = ({4'd0, fh_reg} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, fh_reg};

    assign pix_addr = AW'(AW'(py_reg) * AW'(MAX_WIDTH)) + AW'(px_reg);

    assign blend_word = {8'hFF,
                         mix(color_reg[23:16], ram_rdata[23:16], color_reg[31:24]),
                         mix(color_reg[15:8], ram_rdata[15:8], color_reg[31:24]),
                         mix(color_reg[7:0], ram_rdata[7:0], color_reg[31:24])};

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_BLEND);
    assign ram_addr  = (state_reg == S_CLEAR) ? clr_reg : pix_addr;
    assign ram_wdata = (state_reg == S_CLEAR) ? color_reg : blend_word;

    brlr_ram #(
        .DATA_W(32),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // sample point and disc offsets
    assign r8s  = $signed({9'd0, r8_reg});
    assign xs_c = $signed({{4{sx_reg[15]}}, sx_reg, 4'h0}) + accx_reg;
    assign ys_c = $signed({{4{sy_reg[15]}}, sy_reg, 4'h0}) + accy_reg;
    assign ox_c = $signed({{(16 - CW){1'b0}}, px_reg, 8'h80}) - xs_reg;
    assign oy_c = $signed({{(16 - CH){1'b0}}, py_reg, 8'h80}) - ys_reg;
    assign ox17 = ox_c[16:0];
    assign oy17 = oy_c[16:0];
    assign sqx_full = ox17 * ox17;
    assign sqy_full = oy17 * oy17;
    assign sq_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hit_c    = !line_reg || (sq_sum <= {3'd0, r2_reg});

    assign box_empty    = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);
    assign adv_px       = ({1'b0, px_reg} + 1'b1) < {1'b0, x1_reg};
    assign adv_py       = ({1'b0, py_reg} + 1'b1) < {1'b0, y1_reg};
    assign more_samples = line_reg && (s_reg < steps_reg);

    assign remx_sh  = {remx_reg[12:0], numx_reg[19]};
    assign remy_sh  = {remy_reg[12:0], numy_reg[19]};
    assign racx_sum = {1'b0, racx_reg} + {1'b0, rfx_reg};
    assign racy_sum = {1'b0, racy_reg} + {1'b0, rfy_reg};

    assign dx_c   = $signed({s_data.end_x[15], s_data.end_x})
                  - $signed({s_data.start_x[15], s_data.start_x});
    assign dy_c   = $signed({s_data.end_y[15], s_data.end_y})
                  - $signed({s_data.start_y[15], s_data.start_y});
    assign adx_c  = dx_c[16] ? 17'(-dx_c) : 17'(dx_c);
    assign ady_c  = dy_c[16] ? 17'(-dy_c) : 17'(dy_c);
    assign m_c    = (adx_c > ady_c) ? adx_c : ady_c;
    assign st17_c = (m_c + 17'd15) >> 4;
    assign lwm_c  = (s_data.line_width < 12'd16) ? 12'd16 : s_data.line_width;
    assign r8_c   = {lwm_c, 3'b000};
    assign rdx_c  = {s_data.start_x[15], s_data.start_x[15:4]};
    assign rdy_c  = {s_data.start_y[15], s_data.start_y[15:4]};
    assign t24a   = $signed({{8{s_data.start_x[15]}}, s_data.start_x}) >>> 4;
    assign t24b   = ($signed({{8{s_data.end_x[15]}}, s_data.end_x}) + 24'sd15) >>> 4;

    always_comb begin
        logic signed [23:0] ya, yb, lo, hi;
        state_next   = state_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        m_valid_next = m_valid_reg;
        px_next = px_reg;  x0_next = x0_reg;  x1_next = x1_reg;
        py_next = py_reg;  y0_next = y0_reg;  y1_next = y1_reg;
        clr_next   = clr_reg;
        color_next = color_reg;
        sx_next = sx_reg;  sy_next = sy_reg;
        negx_next = negx_reg;  negy_next = negy_reg;  line_next = line_reg;
        steps_next = steps_reg;  s_next = s_reg;
        numx_next = numx_reg;  numy_next = numy_reg;
        remx_next = remx_reg;  remy_next = remy_reg;
        div_next  = div_reg;
        qfx_next = qfx_reg;  qfy_next = qfy_reg;
        rfx_next = rfx_reg;  rfy_next = rfy_reg;
        accx_next = accx_reg;  accy_next = accy_reg;
        racx_next = racx_reg;  racy_next = racy_reg;
        r8_next = r8_reg;  r2_next = r2_reg;
        xs_next = xs_reg;  ys_next = ys_reg;
        sqx_next = sqx_reg;  sqy_next = sqy_reg;
        res_next = res_reg;
        out_next = out_reg;
        ya = $signed({{8{s_data.start_y[15]}}, s_data.start_y}) >>> 4;
        yb = ($signed({{8{s_data.end_y[15]}}, s_data.end_y}) + 24'sd15) >>> 4;
        lo = 24'sd0;
        hi = 24'sd0;

        if (cfg_valid) begin
            if (cfg_index == CFG_WIDTH) begin
                fw_next = cfg_data;
            end else if (cfg_index == CFG_HEIGHT) begin
                fh_next = cfg_data;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next   = '0;
                    color_next = {s_data.alpha, s_data.blue, s_data.green, s_data.red};
                    sx_next    = s_data.start_x;
                    sy_next    = s_data.start_y;
                    unique case (s_data.action)
                        ACT_CLEAR: begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        ACT_FILL: begin
                            line_next  = 1'b0;
                            x0_next    = CW'(clamp13(t24a, fw13));
                            x1_next    = CW'(clamp13(t24b, fw13));
                            y0_next    = CH'(clamp13(ya, fh13));
                            y1_next    = CH'(clamp13(yb, fh13));
                            state_next = S_BOX;
                        end
                        ACT_LINE: begin
                            line_next  = 1'b1;
                            negx_next  = dx_c[16];
                            negy_next  = dy_c[16];
                            steps_next = (st17_c == 17'd0) ? 13'd1 : st17_c[12:0];
                            numx_next  = {adx_c[15:0], 4'h0};
                            numy_next  = {ady_c[15:0], 4'h0};
                            remx_next  = '0;
                            remy_next  = '0;
                            div_next   = '0;
                            r8_next    = r8_c;
                            r2_next    = 30'(r8_c) * 30'(r8_c);
                            state_next = S_DIV;
                        end
                        ACT_READ: begin
                            if (!rdx_c[12] && !rdy_c[12] && rdx_c < fw13 && rdy_c < fh13) begin
                                px_next    = CW'(rdx_c);
                                py_next    = CH'(rdy_c);
                                state_next = S_RDREQ;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                if (div_reg == 5'd20) begin
                    if (negx_reg && remx_reg != 14'd0) begin
                        qfx_next = -$signed({1'b0, numx_reg}) - 21'sd1;
                        rfx_next = steps_reg - remx_reg[12:0];
                    end else begin
                        qfx_next = negx_reg ? -$signed({1'b0, numx_reg})
                                            : $signed({1'b0, numx_reg});
                        rfx_next = remx_reg[12:0];
                    end
                    if (negy_reg && remy_reg != 14'd0) begin
                        qfy_next = -$signed({1'b0, numy_reg}) - 21'sd1;
                        rfy_next = steps_reg - remy_reg[12:0];
                    end else begin
                        qfy_next = negy_reg ? -$signed({1'b0, numy_reg})
                                            : $signed({1'b0, numy_reg});
                        rfy_next = remy_reg[12:0];
                    end
                    accx_next  = '0;
                    accy_next  = '0;
                    racx_next  = '0;
                    racy_next  = '0;
                    s_next     = '0;
                    state_next = S_SAMPLE;
                end else begin
                    div_next = div_reg + 1'b1;
                    if (remx_sh >= {1'b0, steps_reg}) begin
                        remx_next = remx_sh - {1'b0, steps_reg};
                        numx_next = {numx_reg[18:0], 1'b1};
                    end else begin
                        remx_next = remx_sh;
                        numx_next = {numx_reg[18:0], 1'b0};
                    end
                    if (remy_sh >= {1'b0, steps_reg}) begin
                        remy_next = remy_sh - {1'b0, steps_reg};
                        numy_next = {numy_reg[18:0], 1'b1};
                    end else begin
                        remy_next = remy_sh;
                        numy_next = {numy_reg[18:0], 1'b0};
                    end
                end
            end
            S_SAMPLE: begin
                xs_next = xs_c;
                ys_next = ys_c;
                lo = (xs_c - r8s) >>> 8;
                hi = ((xs_c + r8s + 24'sd255) >>> 8) + 24'sd1;
                x0_next = CW'(clamp13(lo, fw13));
                x1_next = CW'(clamp13(hi, fw13));
                lo = (ys_c - r8s) >>> 8;
                hi = ((ys_c + r8s + 24'sd255) >>> 8) + 24'sd1;
                y0_next = CH'(clamp13(lo, fh13));
                y1_next = CH'(clamp13(hi, fh13));
                state_next = S_BOX;
            end
            S_BOX: begin
                px_next = x0_reg;
                py_next = y0_reg;
                state_next = box_empty ? S_DONE : S_SQ;
            end
            S_SQ: begin
                sqx_next   = sqx_full[31:0];
                sqy_next   = sqy_full[31:0];
                state_next = S_TEST;
            end
            S_TEST: begin
                state_next = hit_c ? S_BLEND : S_DONE;
            end
            S_BLEND: begin
                state_next = S_DONE;
            end
            S_RDREQ: begin
                state_next = S_RDWAIT;
            end
            S_RDWAIT: begin
                res_next = '{pixel_red: ram_rdata[7:0], pixel_green: ram_rdata[15:8],
                             pixel_blue: ram_rdata[23:16], pixel_alpha: ram_rdata[31:24],
                             read_valid: 1'b1};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // pixel walk, box walk and sample stepping
        if ((state_reg == S_BLEND) || (state_reg == S_TEST && !hit_c)
            || (state_reg == S_BOX && box_empty)) begin
            if (state_reg != S_BOX && adv_px) begin
                px_next    = px_reg + 1'b1;
                state_next = S_SQ;
            end else if (state_reg != S_BOX && adv_py) begin
                px_next    = x0_reg;
                py_next    = py_reg + 1'b1;
                state_next = S_SQ;
            end else if (more_samples) begin
                s_next = s_reg + 1'b1;
                if (racx_sum >= {1'b0, steps_reg}) begin
                    racx_next = 13'(racx_sum - {1'b0, steps_reg});
                    accx_next = accx_reg + 24'(qfx_reg) + 24'sd1;
                end else begin
                    racx_next = racx_sum[12:0];
                    accx_next = accx_reg + 24'(qfx_reg);
                end
                if (racy_sum >= {1'b0, steps_reg}) begin
                    racy_next = 13'(racy_sum - {1'b0, steps_reg});
                    accy_next = accy_reg + 24'(qfy_reg) + 24'sd1;
                end else begin
                    racy_next = racy_sum[12:0];
                    accy_next = accy_reg + 24'(qfy_reg);
                end
                state_next = S_SAMPLE;
            end else begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fw_reg      <= 9'd256;
            fh_reg      <= 9'd256;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg <= px_next;  x0_reg <= x0_next;  x1_reg <= x1_next;
        py_reg <= py_next;  y0_reg <= y0_next;  y1_reg <= y1_next;
        clr_reg   <= clr_next;
        color_reg <= color_next;
        sx_reg <= sx_next;  sy_reg <= sy_next;
        negx_reg <= negx_next;  negy_reg <= negy_next;  line_reg <= line_next;
        steps_reg <= steps_next;  s_reg <= s_next;
        numx_reg <= numx_next;  numy_reg <= numy_next;
        remx_reg <= remx_next;  remy_reg <= remy_next;
        div_reg  <= div_next;
        qfx_reg <= qfx_next;  qfy_reg <= qfy_next;
        rfx_reg <= rfx_next;  rfy_reg <= rfy_next;
        accx_reg <= accx_next;  accy_reg <= accy_next;
        racx_reg <= racx_next;  racy_reg <= racy_next;
        r8_reg <= r8_next;  r2_reg <= r2_next;
        xs_reg <= xs_next;  ys_reg <= ys_next;
        sqx_reg <= sqx_next;  sqy_reg <= sqy_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_blend_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BLEND) |-> $past(state_reg) == S_TEST)
        else $error("blend without a preceding store read");

    a_write_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BLEND) |-> (13'(px_reg) < fw13 && 13'(py_reg) < fh13))
        else $error("pixel write outside the active frame");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !ram_we)
        else $error("store write with no command in progress");

    a_sample_line_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SAMPLE) |-> line_reg)
        else $error("sample stepping outside a line command");
`endif
endmodule
